// ===== hw/rtl/aging_priority_task_picker_macros.svh =====
// assertion macros for the checker in aptp_checker.sv
`ifndef AGING_PRIORITY_TASK_PICKER_MACROS_SVH
`define AGING_PRIORITY_TASK_PICKER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define APTP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define APTP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/aptp_pkg.sv =====
package aptp_pkg;

    localparam int NUM_SLOTS_DEFAULT = 16;

    localparam int OP_W       = 2;
    localparam int SP_W       = 32;
    localparam int SLOT_W     = 4;
    localparam int PRIO_W     = 4;
    localparam int SLEEP_W    = 16;
    localparam int AGE_W      = 16;
    localparam int RATIO_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    // (max - prio) * ratio fits 13 bits signed, score adds a 16-bit age
    localparam int PROD_W     = 14;
    localparam int SCORE_W    = 18;

    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
    localparam logic [OP_W-1:0] OP_SAVE     = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_RATIO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PRIORITY   = 1'd1;

    localparam logic [RATIO_W-1:0] RATIO_RESET   = 8'd2;
    localparam logic [PRIO_W-1:0]  MAX_PRI_RESET = 4'd4;
    localparam logic [AGE_W-1:0]   AGE_MAX       = '1;

    typedef struct packed {
        logic               blocked;
        logic [PRIO_W-1:0]  prio;
        logic [SLEEP_W-1:0] sleep;
        logic [AGE_W-1:0]   age;
    } slot_state_t;

    localparam int STATE_W = $bits(slot_state_t);

    typedef struct packed {
        logic accept;
        logic walk_issue;
        logic pick;
        logic fetch;
        logic push_out;
    } aptp_cmd_t;

    typedef struct packed {
        logic is_schedule;
        logic last_issue;
        logic pipe_busy;
    } aptp_status_t;

endpackage

// ===== hw/rtl/aptp_ram.sv =====
module aptp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = aptp_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/aptp_ctrl.sv =====
module aptp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  aptp_pkg::aptp_status_t status,
    output aptp_pkg::aptp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PICK  = 6'b001000,
        S_FETCH = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.is_schedule ? S_WALK : S_DONE;
                end
            end
            S_WALK:
            begin
                cmd.walk_issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the last slot to leave the scoring stages
                if (!status.pipe_busy)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/aptp_datapath.sv =====
module aptp_datapath #(
    parameter int NUM_SLOTS = aptp_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  aptp_pkg::aptp_cmd_t                 cmd,
    output aptp_pkg::aptp_status_t              status,
    input  logic [aptp_pkg::OP_W-1:0]           operation,
    input  logic [aptp_pkg::SP_W-1:0]           saved_sp,
    input  logic [aptp_pkg::SLOT_W-1:0]         slot,
    input  logic                                in_use,
    input  logic [aptp_pkg::PRIO_W-1:0]         priority_req,
    input  logic signed [aptp_pkg::SLEEP_W-1:0] sleep_count,
    input  logic                                blocked,
    input  logic                                cfg_write,
    input  logic [aptp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aptp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [aptp_pkg::SP_W-1:0]           next_sp,
    output logic [aptp_pkg::SLOT_W-1:0]         next_slot,
    output logic                                idle_chosen
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam int SP_W    = aptp_pkg::SP_W;
    localparam int SLOT_W  = aptp_pkg::SLOT_W;
    localparam int PRIO_W  = aptp_pkg::PRIO_W;
    localparam int SLEEP_W = aptp_pkg::SLEEP_W;
    localparam int AGE_W   = aptp_pkg::AGE_W;
    localparam int RATIO_W = aptp_pkg::RATIO_W;
    localparam int PROD_W  = aptp_pkg::PROD_W;
    localparam int SCORE_W = aptp_pkg::SCORE_W;
    localparam int STATE_W = aptp_pkg::STATE_W;

    // configuration
    logic [RATIO_W-1:0] ratio_reg;
    logic [PRIO_W-1:0]  max_pri_reg;

    // scheduler state
    logic [NUM_SLOTS-1:0] in_use_reg;
    logic [SP_W-1:0]      idle_sp_reg;
    logic                 cur_idle_reg;
    logic [IDX_W-1:0]     cur_idx_reg;
    logic                 first_call_reg;

    // walk pipeline
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      v1_reg;
    logic [IDX_W-1:0]          idx1_reg;
    logic                      v2_reg;
    logic [IDX_W-1:0]          idx2_reg;
    logic                      cand2_reg;
    logic signed [PROD_W-1:0]  prod2_reg;
    aptp_pkg::slot_state_t     entry2_reg;
    logic signed [SCORE_W-1:0] best_reg;
    logic                      found_reg;
    logic [IDX_W-1:0]          win_idx_reg;
    aptp_pkg::slot_state_t     win_entry_reg;

    // result and output registers
    logic [SP_W-1:0]   res_sp_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              res_idle_reg;
    logic [SP_W-1:0]   out_sp_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_idle_reg;

    // rams
    logic               st_we;
    logic [IDX_W-1:0]   st_waddr;
    logic [STATE_W-1:0] st_wdata;
    logic [STATE_W-1:0] st_rdata;
    logic               sp_we;
    logic [IDX_W-1:0]   sp_waddr;
    logic [SP_W-1:0]    sp_wdata;
    logic [SP_W-1:0]    sp_rdata;

    // decode of the incoming item
    logic                    is_sched;
    logic                    is_save;
    logic                    is_write;
    logic                    saves_sp;
    logic                    slot_ok;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [IDX_W-1:0]        slot_idx;
    aptp_pkg::slot_state_t   wr_entry;

    // scoring
    aptp_pkg::slot_state_t     entry1;
    aptp_pkg::slot_state_t     entry2_next;
    logic                      live1;
    logic                      asleep1;
    logic                      cand1;
    logic                      wb1;
    logic signed [4:0]         diff1;
    logic signed [PROD_W-1:0]  diff_x;
    logic signed [PROD_W-1:0]  ratio_x;
    logic signed [PROD_W-1:0]  prod1;
    logic signed [SCORE_W-1:0] prod_x;
    logic signed [SCORE_W-1:0] age_x;
    logic signed [SCORE_W-1:0] score2;
    logic                      better2;
    aptp_pkg::slot_state_t     win_clear;
    logic [IDX_W+SLOT_W-1:0]   win_ext;

    assign is_sched = (operation == aptp_pkg::OP_SCHEDULE);
    assign is_save  = (operation == aptp_pkg::OP_SAVE);
    assign is_write = (operation == aptp_pkg::OP_WRITE);
    assign saves_sp = cmd.accept && (is_sched || is_save);
    assign slot_ok  = (int'(slot) < NUM_SLOTS);
    assign slot_ext = {{IDX_W{1'b0}}, slot};
    assign slot_idx = slot_ext[IDX_W-1:0];

    assign wr_entry.blocked = blocked;
    assign wr_entry.prio    = priority_req;
    assign wr_entry.sleep   = sleep_count;
    assign wr_entry.age     = '0;

    assign status.is_schedule = is_sched;
    assign status.last_issue  = (rd_idx_reg == LAST_IDX);
    assign status.pipe_busy   = v1_reg || v2_reg;

    // stage 1: slot entry from ram, update and product
    always_comb
    begin
        entry1      = aptp_pkg::slot_state_t'(st_rdata);
        live1       = in_use_reg[idx1_reg];
        asleep1     = entry1.sleep[SLEEP_W-1];
        entry2_next = entry1;
        if (asleep1)
        begin
            entry2_next.sleep = entry1.sleep + 1'b1;
        end
        else if (!entry1.blocked && (entry1.age != aptp_pkg::AGE_MAX))
        begin
            entry2_next.age = entry1.age + 1'b1;
        end
        cand1   = live1 && !asleep1 && !entry1.blocked;
        wb1     = v1_reg && live1 && (asleep1 || !entry1.blocked);
        diff1   = signed'({1'b0, max_pri_reg}) - signed'({1'b0, entry1.prio});
        diff_x  = {{(PROD_W - 5){diff1[4]}}, diff1};
        ratio_x = signed'({{(PROD_W - RATIO_W){1'b0}}, ratio_reg});
        prod1   = diff_x * ratio_x;
    end

    // stage 2: score and running maximum, strict so the lowest index wins ties
    assign prod_x  = {{(SCORE_W - PROD_W){prod2_reg[PROD_W-1]}}, prod2_reg};
    assign age_x   = signed'({{(SCORE_W - AGE_W){1'b0}}, entry2_reg.age});
    assign score2  = prod_x + age_x;
    assign better2 = v2_reg && cand2_reg && (score2 > best_reg);

    always_comb
    begin
        win_clear     = win_entry_reg;
        win_clear.age = '0;
    end

    assign win_ext = {{SLOT_W{1'b0}}, win_idx_reg};

    // state ram write port: slot write, walk write-back, winner age clear
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = idx1_reg;
        st_wdata = entry2_next;
        if (cmd.accept && is_write && slot_ok)
        begin
            st_we    = 1'b1;
            st_waddr = slot_idx;
            st_wdata = wr_entry;
        end
        else if (wb1)
        begin
            st_we = 1'b1;
        end
        else if (cmd.pick && found_reg)
        begin
            st_we    = 1'b1;
            st_waddr = win_idx_reg;
            st_wdata = win_clear;
        end
    end

    // stack pointer ram write port: save into current task, or slot write
    always_comb
    begin
        sp_we    = 1'b0;
        sp_waddr = cur_idx_reg;
        sp_wdata = saved_sp;
        if (saves_sp && !first_call_reg && !cur_idle_reg)
        begin
            sp_we = 1'b1;
        end
        else if (cmd.accept && is_write && slot_ok)
        begin
            sp_we    = 1'b1;
            sp_waddr = slot_idx;
        end
    end

    aptp_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_SLOTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (cmd.walk_issue),
        .raddr (rd_idx_reg),
        .rdata (st_rdata)
    );

    aptp_ram #(
        .WIDTH (SP_W),
        .DEPTH (NUM_SLOTS)
    ) u_sp_ram (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .re    (cmd.pick),
        .raddr (win_idx_reg),
        .rdata (sp_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg      <= aptp_pkg::RATIO_RESET;
            max_pri_reg    <= aptp_pkg::MAX_PRI_RESET;
            in_use_reg     <= '0;
            idle_sp_reg    <= '0;
            cur_idle_reg   <= 1'b1;
            cur_idx_reg    <= '0;
            first_call_reg <= 1'b1;
            rd_idx_reg     <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    aptp_pkg::REG_PRIORITY_RATIO: ratio_reg   <= cfg_data;
                    aptp_pkg::REG_MAX_PRIORITY:   max_pri_reg <= cfg_data[PRIO_W-1:0];
                    default:                      ratio_reg   <= ratio_reg;
                endcase
            end
            if (saves_sp)
            begin
                first_call_reg <= 1'b0;
                if (!first_call_reg && cur_idle_reg)
                begin
                    idle_sp_reg <= saved_sp;
                end
            end
            if (cmd.accept && is_write && slot_ok)
            begin
                in_use_reg[slot_idx] <= in_use;
            end
            if (cmd.accept)
            begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.walk_issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (better2)
                begin
                    found_reg <= 1'b1;
                end
            end
            v1_reg <= cmd.walk_issue;
            v2_reg <= v1_reg;
            if (cmd.pick)
            begin
                cur_idle_reg <= !found_reg;
                cur_idx_reg  <= win_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg   <= rd_idx_reg;
        idx2_reg   <= idx1_reg;
        cand2_reg  <= cand1;
        prod2_reg  <= prod1;
        entry2_reg <= entry2_next;
        if (cmd.accept)
        begin
            best_reg     <= '1;
            res_sp_reg   <= '0;
            res_slot_reg <= '0;
            res_idle_reg <= 1'b0;
        end
        else
        begin
            if (better2)
            begin
                best_reg      <= score2;
                win_idx_reg   <= idx2_reg;
                win_entry_reg <= entry2_reg;
            end
            if (cmd.fetch)
            begin
                res_sp_reg   <= found_reg ? sp_rdata : idle_sp_reg;
                res_slot_reg <= found_reg ? win_ext[SLOT_W-1:0] : '0;
                res_idle_reg <= !found_reg;
            end
        end
        if (cmd.push_out)
        begin
            out_sp_reg   <= res_sp_reg;
            out_slot_reg <= res_slot_reg;
            out_idle_reg <= res_idle_reg;
        end
    end

    assign next_sp     = out_sp_reg;
    assign next_slot   = out_slot_reg;
    assign idle_chosen = out_idle_reg;

endmodule

// ===== hw/rtl/aging_priority_task_picker.sv =====
// channel | signals                                        | direction
// --------+------------------------------------------------+----------
// in      | in_valid, in_ready, operation, saved_sp, slot, | into block
//         | in_use, priority_req, sleep_count, blocked     |
// out     | out_valid, out_ready, next_sp, next_slot,      | out of block
//         | idle_chosen                                    |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | into block
//
// a schedule item walks the slots before it raises out_valid: the slot walk
// reads one entry a cycle from the state ram, the two scoring stages drain,
// then the winner's age is cleared and its stack pointer read from the pointer ram.
// save, write and unused items raise out_valid without a walk. one item is worked
// on at a time; the next is taken the cycle after its result enters the output register,
// and a held result stalls the input.
// reset is asynchronous, active low, and needs no clearing pass; cfg_ready is always high.
module aging_priority_task_picker #(
    parameter int NUM_SLOTS = aptp_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [aptp_pkg::OP_W-1:0]           operation,
    input  logic [aptp_pkg::SP_W-1:0]           saved_sp,
    input  logic [aptp_pkg::SLOT_W-1:0]         slot,
    input  logic                                in_use,
    input  logic [aptp_pkg::PRIO_W-1:0]         priority_req,
    input  logic signed [aptp_pkg::SLEEP_W-1:0] sleep_count,
    input  logic                                blocked,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [aptp_pkg::SP_W-1:0]           next_sp,
    output logic [aptp_pkg::SLOT_W-1:0]         next_slot,
    output logic                                idle_chosen,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aptp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aptp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    aptp_pkg::aptp_cmd_t    cmd;
    aptp_pkg::aptp_status_t status;

    assign cfg_ready = 1'b1;

    aptp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    aptp_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .saved_sp     (saved_sp),
        .slot         (slot),
        .in_use       (in_use),
        .priority_req (priority_req),
        .sleep_count  (sleep_count),
        .blocked      (blocked),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .next_sp      (next_sp),
        .next_slot    (next_slot),
        .idle_chosen  (idle_chosen)
    );

endmodule

// ===== hw/rtl/aptp_checker.sv =====
`include "aging_priority_task_picker_macros.svh"

module aptp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [aptp_pkg::SP_W-1:0]   next_sp,
    input logic [aptp_pkg::SLOT_W-1:0] next_slot,
    input logic                        idle_chosen
);

    // a stalled result keeps its payload
    `APTP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_sp) && $stable(next_slot) && $stable(idle_chosen), "result changed while stalled")

    // the idle task carries slot zero
    `APTP_ASSERT_IMP(a_idle_slot_zero, out_valid && idle_chosen, next_slot == 4'd0, "idle result with nonzero slot")

    // one transaction in work at a time
    `APTP_ASSERT_NXT(a_one_in_work, in_valid && in_ready, !in_ready, "input taken while busy")

    // a new result only appears after the block was busy with an item
    `APTP_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(!in_ready), "result without work")

endmodule

bind aging_priority_task_picker aptp_checker u_aptp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .next_sp     (next_sp),
    .next_slot   (next_slot),
    .idle_chosen (idle_chosen)
);

// ===== bench/aptp_pick_checker.sv =====
`timescale 1ns / 100ps

module aptp_pick_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [aptp_pkg::OP_W-1:0]           operation,
    input  logic [aptp_pkg::SP_W-1:0]           saved_sp,
    input  logic [aptp_pkg::SLOT_W-1:0]         slot,
    input  logic                                in_use,
    input  logic [aptp_pkg::PRIO_W-1:0]         priority_req,
    input  logic signed [aptp_pkg::SLEEP_W-1:0] sleep_count,
    input  logic                                blocked,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [aptp_pkg::SP_W-1:0]           next_sp,
    input  logic [aptp_pkg::SLOT_W-1:0]         next_slot,
    input  logic                                idle_chosen,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [aptp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aptp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatch_count,
    output int                                  picks_pending
);

    localparam int SLOTS   = aptp_pkg::NUM_SLOTS_DEFAULT;
    localparam int SP_W    = aptp_pkg::SP_W;
    localparam int SLOT_W  = aptp_pkg::SLOT_W;
    localparam int PRIO_W  = aptp_pkg::PRIO_W;
    localparam int SLEEP_W = aptp_pkg::SLEEP_W;
    localparam int RATIO_W = aptp_pkg::RATIO_W;

    typedef struct packed {
        logic [SP_W-1:0]   sp;
        logic [SLOT_W-1:0] slot;
        logic              idle;
    } pick_t;

    logic                  live_q [SLOTS];
    aptp_pkg::slot_state_t task_q [SLOTS];
    logic [SP_W-1:0]       task_sp_q [SLOTS];
    logic [SP_W-1:0]       idle_sp_q;
    int                    running;        // SLOTS stands for the idle task
    bit                    first_call_q;
    logic [RATIO_W-1:0]    ratio_q;
    logic [PRIO_W-1:0]     max_pri_q;
    pick_t                 expected_picks [$];

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            live_q[i]    = 1'b0;
            task_q[i]    = '0;
            task_sp_q[i] = '0;
        end
        idle_sp_q      = '0;
        running        = SLOTS;
        first_call_q   = 1'b1;
        ratio_q        = aptp_pkg::RATIO_RESET;
        max_pri_q      = aptp_pkg::MAX_PRI_RESET;
        mismatch_count = 0;
        picks_pending  = 0;
    end

    function automatic void save_pointer(logic [SP_W-1:0] sp);
        if (first_call_q)
            first_call_q = 1'b0;
        else if (running < SLOTS)
            task_sp_q[running] = sp;
        else
            idle_sp_q = sp;
    endfunction

    function automatic pick_t pick_next(logic [SP_W-1:0] sp);
        int    best;
        int    score;
        int    winner;
        int    i;
        pick_t res;
        best   = -1;
        winner = -1;
        res    = '0;
        save_pointer(sp);
        for (i = 0; i < SLOTS; i++)
        begin
            if (live_q[i])
            begin
                if (task_q[i].sleep[SLEEP_W-1])
                    task_q[i].sleep = task_q[i].sleep + 1'b1;
                else if (!task_q[i].blocked)
                begin
                    if (task_q[i].age != aptp_pkg::AGE_MAX)
                        task_q[i].age = task_q[i].age + 1'b1;
                    // priority above the maximum gives a negative weight
                    score = (int'(max_pri_q) - int'(task_q[i].prio)) * int'(ratio_q)
                            + int'(task_q[i].age);
                    if (score > best)
                    begin
                        best   = score;
                        winner = i;
                    end
                end
            end
        end
        if (winner >= 0)
        begin
            task_q[winner].age = '0;
            running  = winner;
            res.sp   = task_sp_q[winner];
            res.slot = winner[SLOT_W-1:0];
        end
        else
        begin
            running  = SLOTS;
            res.sp   = idle_sp_q;
            res.idle = 1'b1;
        end
        return res;
    endfunction

    function automatic pick_t apply_item();
        pick_t res;
        res = '0;
        case (operation)
            aptp_pkg::OP_SCHEDULE: res = pick_next(saved_sp);
            aptp_pkg::OP_SAVE:     save_pointer(saved_sp);
            aptp_pkg::OP_WRITE:
            begin
                if (int'(slot) < SLOTS)
                begin
                    live_q[slot]        = in_use;
                    task_q[slot].blocked = blocked;
                    task_q[slot].prio    = priority_req;
                    task_q[slot].sleep   = sleep_count;
                    task_q[slot].age     = '0;
                    task_sp_q[slot]      = saved_sp;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [SP_W-1:0] want, logic [SP_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : watch
        pick_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == aptp_pkg::REG_PRIORITY_RATIO)
                    ratio_q = cfg_data[RATIO_W-1:0];
                else if (cfg_index == aptp_pkg::REG_MAX_PRIORITY)
                    max_pri_q = cfg_data[PRIO_W-1:0];
            end
            // the result leaving now belongs to an item accepted earlier
            if (out_valid && out_ready)
            begin
                if (expected_picks.size() == 0)
                    flag_mismatch("unexpected transaction, next_sp", '0, next_sp);
                else
                begin
                    want = expected_picks.pop_front();
                    if (next_sp !== want.sp)
                        flag_mismatch("next_sp", want.sp, next_sp);
                    if (next_slot !== want.slot)
                        flag_mismatch("next_slot", SP_W'(want.slot), SP_W'(next_slot));
                    if (idle_chosen !== want.idle)
                        flag_mismatch("idle_chosen", SP_W'(want.idle), SP_W'(idle_chosen));
                end
            end
            if (in_valid && in_ready)
                expected_picks.push_back(apply_item());
            picks_pending = expected_picks.size();
        end
    end

endmodule

// ===== bench/tb_aging_priority_task_picker.sv =====
`timescale 1ns / 100ps

module tb_aging_priority_task_picker;

    localparam int OP_W       = aptp_pkg::OP_W;
    localparam int SP_W       = aptp_pkg::SP_W;
    localparam int SLOT_W     = aptp_pkg::SLOT_W;
    localparam int PRIO_W     = aptp_pkg::PRIO_W;
    localparam int SLEEP_W    = aptp_pkg::SLEEP_W;
    localparam int CFG_IDX_W  = aptp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = aptp_pkg::CFG_DATA_W;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = aptp_pkg::NUM_SLOTS_DEFAULT + 10;
    localparam int HOLD_CYCLES  = 300;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [OP_W-1:0]          operation;
    logic [SP_W-1:0]          saved_sp;
    logic [SLOT_W-1:0]        slot;
    logic                     in_use;
    logic [PRIO_W-1:0]        priority_req;
    logic signed [SLEEP_W-1:0] sleep_count;
    logic                     blocked;
    logic                     out_valid;
    logic                     out_ready;
    logic [SP_W-1:0]          next_sp;
    logic [SLOT_W-1:0]        next_slot;
    logic                     idle_chosen;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int mismatch_count;
    int picks_pending;
    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_left = 0;

    aging_priority_task_picker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .saved_sp     (saved_sp),
        .slot         (slot),
        .in_use       (in_use),
        .priority_req (priority_req),
        .sleep_count  (sleep_count),
        .blocked      (blocked),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .next_sp      (next_sp),
        .next_slot    (next_slot),
        .idle_chosen  (idle_chosen),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    aptp_pick_checker pick_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .saved_sp       (saved_sp),
        .slot           (slot),
        .in_use         (in_use),
        .priority_req   (priority_req),
        .sleep_count    (sleep_count),
        .blocked        (blocked),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_sp        (next_sp),
        .next_slot      (next_slot),
        .idle_chosen    (idle_chosen),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .picks_pending  (picks_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver side, with an occasional long hold-off to back up the block
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("** aging_priority_task_picker: FAILED **");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SP_W-1:0] sp,
                             input logic [SLOT_W-1:0] idx, input logic live,
                             input logic [PRIO_W-1:0] prio,
                             input logic signed [SLEEP_W-1:0] sleep, input logic blk);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        saved_sp     <= sp;
        slot         <= idx;
        in_use       <= live;
        priority_req <= prio;
        sleep_count  <= sleep;
        blocked      <= blk;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        int                        kind;
        int                        r;
        logic signed [SLEEP_W-1:0] sleep;
        kind = $urandom_range(99);
        r    = $urandom_range(9);
        // mostly awake or briefly asleep, so sleepers wake up within a phase
        if (r < 5)
            sleep = SLEEP_W'($urandom_range(100));
        else if (r < 8)
            sleep = SLEEP_W'(-int'($urandom_range(6, 1)));
        else
            sleep = SLEEP_W'($urandom);
        if (kind < 40)
            send_item(aptp_pkg::OP_WRITE, $urandom, SLOT_W'($urandom_range(15)),
                      $urandom_range(9) != 0, PRIO_W'($urandom_range(15)), sleep,
                      $urandom_range(4) == 0);
        else if (kind < 80)
            send_item(aptp_pkg::OP_SCHEDULE, $urandom, SLOT_W'($urandom), 1'($urandom),
                      PRIO_W'($urandom), sleep, 1'($urandom));
        else if (kind < 95)
            send_item(aptp_pkg::OP_SAVE, $urandom, SLOT_W'($urandom), 1'($urandom),
                      PRIO_W'($urandom), sleep, 1'($urandom));
        else
            send_item(OP_UNUSED, $urandom, SLOT_W'($urandom), 1'($urandom),
                      PRIO_W'($urandom), sleep, 1'($urandom));
    endtask

    // leaves cfg_valid high; the caller lowers it after the last register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic drain_picks();
        do
            @(negedge clk);
        while (picks_pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int n, input int gap, input int stall,
                             input logic [CFG_DATA_W-1:0] ratio,
                             input logic [CFG_DATA_W-1:0] max_pri, input int hold_at);
        drain_picks();
        write_reg(aptp_pkg::REG_PRIORITY_RATIO, ratio);
        write_reg(aptp_pkg::REG_MAX_PRIORITY, max_pri);
        cfg_valid <= 1'b0;
        gap_pct   = gap;
        stall_pct = stall;
        for (int k = 0; k < n; k++)
        begin
            if (k == hold_at)
                hold_left = HOLD_CYCLES;
            send_random_item();
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = '0;
        saved_sp     = '0;
        slot         = '0;
        in_use       = 1'b0;
        priority_req = '0;
        sleep_count  = '0;
        blocked      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first call skips the save, empty table picks idle
        send_item(aptp_pkg::OP_SCHEDULE, 32'hFFFF_FFFF, 4'hF, 1'b1, 4'hF, 16'sh7FFF, 1'b1);
        send_item(aptp_pkg::OP_SAVE, 32'hA5A5_5A5A, '0, 1'b0, '0, '0, 1'b0);
        send_item(aptp_pkg::OP_SCHEDULE, 32'h0000_0000, '0, 1'b0, '0, '0, 1'b0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 4'hF, 1'b1, 4'hF, -16'sd1, 1'b1);
        // equal priorities in slots 0 and 1 for a tie
        send_item(aptp_pkg::OP_WRITE, 32'h1000_0000, 4'd0, 1'b1, 4'd0, 16'sd0, 1'b0);
        send_item(aptp_pkg::OP_WRITE, 32'h0000_1111, 4'd1, 1'b1, 4'd0, 16'sd0, 1'b0);
        send_item(aptp_pkg::OP_WRITE, 32'hFFFF_FFFF, 4'd15, 1'b1, 4'd15, 16'sh7FFF, 1'b0);
        send_item(aptp_pkg::OP_WRITE, 32'h0000_0003, 4'd3, 1'b1, 4'd2, 16'sh8000, 1'b0);
        send_item(aptp_pkg::OP_WRITE, 32'h0000_0005, 4'd5, 1'b1, 4'd0, -16'sd1, 1'b1);
        send_item(aptp_pkg::OP_WRITE, 32'h0000_7777, 4'd7, 1'b0, 4'd15, -16'sd1, 1'b1);
        send_item(aptp_pkg::OP_SCHEDULE, 32'hDEAD_BEEF, '0, 1'b0, '0, '0, 1'b0);
        send_item(aptp_pkg::OP_SCHEDULE, 32'h0123_4567, '0, 1'b0, '0, '0, 1'b0);
        send_item(aptp_pkg::OP_SAVE, 32'h0000_CAFE, '0, 1'b0, '0, '0, 1'b0);
        send_item(aptp_pkg::OP_SCHEDULE, 32'h89AB_CDEF, '0, 1'b0, '0, '0, 1'b0);
        // free whichever task runs, then save into the freed slot
        send_item(aptp_pkg::OP_WRITE, 32'h0000_0000, 4'd0, 1'b0, 4'd0, 16'sd0, 1'b0);
        send_item(aptp_pkg::OP_WRITE, 32'h0000_0000, 4'd1, 1'b0, 4'd0, 16'sd0, 1'b0);
        send_item(aptp_pkg::OP_SAVE, 32'h0BAD_F00D, '0, 1'b0, '0, '0, 1'b0);
        // only a negative score left awake: idle is picked
        send_item(aptp_pkg::OP_SCHEDULE, 32'h5555_AAAA, '0, 1'b0, '0, '0, 1'b0);
        send_item(aptp_pkg::OP_SCHEDULE, 32'hAAAA_5555, '0, 1'b0, '0, '0, 1'b0);
        send_item(aptp_pkg::OP_WRITE, 32'h0000_0055, 4'd5, 1'b1, 4'd4, 16'sd0, 1'b0);
        send_item(aptp_pkg::OP_SCHEDULE, 32'h7FFF_FFFF, '0, 1'b0, '0, '0, 1'b0);
        send_item(aptp_pkg::OP_SCHEDULE, 32'h8000_0000, '0, 1'b0, '0, '0, 1'b0);
        in_valid <= 1'b0;

        run_phase(410, 0, 0, 8'd255, 8'd15, 150);
        // upper data bits set, the priority register keeps only its low bits
        run_phase(405, 49, 0, 8'd0, 8'hF0, -1);
        run_phase(405, 0, 49, 8'd1, 8'd7, -1);
        run_phase(410, 30, 30, CFG_DATA_W'($urandom_range(255)),
                  CFG_DATA_W'($urandom_range(255)), -1);

        drain_picks();
        if (mismatch_count == 0 && picks_pending == 0)
            $display("** aging_priority_task_picker: PASSED **");
        else
            $display("** aging_priority_task_picker: FAILED **");
        $finish;
    end

endmodule
